// File: hw/rtl/b64u_pkg.sv
// shared types, character codes and symbol decode for the base64url stream decoder
`timescale 1ns / 1ps

package b64u_pkg;

    // character codes with special meaning
    localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_Z  = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_Z  = 8'h7A;  // 'z'
    localparam logic [7:0] CH_DIG_0 = 8'h30;  // '0'
    localparam logic [7:0] CH_DIG_9 = 8'h39;  // '9'

    localparam int SYM_W     = 6;
    localparam int GROUP_LEN = 4;
    localparam int MAX_RES   = 3;

    // input beat
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    // decoded symbol: valid flag plus 6-bit value
    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] val;
    } t_sym;

    // results of one input beat, handed from the group logic to the output buffer
    typedef struct packed {
        logic [1:0]            cnt;      // number of output beats, 0..3
        logic                  marker;   // empty end marker
        logic                  msg_end;  // beat closes the message
        logic [MAX_RES-1:0][7:0] bytes;
    } t_group_res;

    // map one character to its 6-bit value, '=' counts as zero
    function automatic t_sym sym_decode(input logic [7:0] ch);
        t_sym s;
        s = '0;
        if (ch inside {[CH_UP_A:CH_UP_Z]}) begin
            s = '{ok: 1'b1, val: SYM_W'(ch - CH_UP_A)};
        end else if (ch inside {[CH_LO_A:CH_LO_Z]}) begin
            s = '{ok: 1'b1, val: SYM_W'(ch - CH_LO_A + 8'd26)};
        end else if (ch inside {[CH_DIG_0:CH_DIG_9]}) begin
            s = '{ok: 1'b1, val: SYM_W'(ch - CH_DIG_0 + 8'd52)};
        end else if (ch == CH_MINUS || ch == CH_PLUS) begin
            s = '{ok: 1'b1, val: SYM_W'(62)};
        end else if (ch == CH_UNDER || ch == CH_SLASH) begin
            s = '{ok: 1'b1, val: SYM_W'(63)};
        end else if (ch == CH_PAD) begin
            s = '{ok: 1'b1, val: '0};
        end
        return s;
    endfunction

endpackage

// File: hw/rtl/b64u_group.sv
// group state and byte assembly for one character beat
`timescale 1ns / 1ps

module b64u_group
    import b64u_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_in_item   i_item,
    output t_group_res o_res
);

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    t_sym       r_held [MAX_RES];
    logic       r_third_pad;
    logic       n_third_pad;
    logic       r_stopped;
    logic       n_stopped;

    t_sym       v;
    logic       pad;
    logic       last;
    logic       complete;
    t_sym       a;
    t_sym       b;
    t_sym       c;
    t_sym       d;
    logic       cpad;
    logic       dpad;
    logic       emit1;
    logic       emit2;
    logic       emit3;
    logic [1:0] nbytes;

    // decode the current character and line up the four group symbols
    always_comb begin
        v        = sym_decode(i_item.in_char);
        pad      = (i_item.in_char == CH_PAD);
        last     = i_item.in_last;
        complete = (r_pos == 2'd3) || last;

        a = (r_pos == 2'd0) ? v : r_held[0];

        if (r_pos == 2'd0) begin
            b = '{ok: 1'b1, val: '0};
        end else if (r_pos == 2'd1) begin
            b = v;
        end else begin
            b = r_held[1];
        end

        if (r_pos == 2'd2) begin
            c    = v;
            cpad = pad;
        end else if (r_pos == 2'd3) begin
            c    = r_held[2];
            cpad = r_third_pad;
        end else begin
            c    = '{ok: 1'b1, val: '0};
            cpad = 1'b1;
        end

        d    = (r_pos == 2'd3) ? v : '{ok: 1'b1, val: '0};
        dpad = (r_pos == 2'd3) ? pad : 1'b1;
    end

    // byte emission rules
    always_comb begin
        emit1 = complete && !r_stopped && a.ok && b.ok;
        emit2 = emit1 && !cpad && c.ok;
        emit3 = emit2 && !dpad && d.ok;
        nbytes = {1'b0, emit1} + {1'b0, emit2} + {1'b0, emit3};

        o_res.msg_end = last;
        o_res.marker  = last && (nbytes == 2'd0);
        o_res.cnt     = o_res.marker ? 2'd1 : nbytes;
        o_res.bytes[0] = o_res.marker ? 8'd0 : {a.val, b.val[5:4]};
        o_res.bytes[1] = {b.val[3:0], c.val[5:2]};
        o_res.bytes[2] = {c.val[1:0], d.val};
    end

    // next group state
    always_comb begin
        n_pos       = complete ? 2'd0 : r_pos + 2'd1;
        n_third_pad = r_third_pad;
        if (r_pos == 2'd2) begin
            n_third_pad = pad;
        end
        n_stopped = r_stopped;
        if (complete && !r_stopped && !(a.ok && b.ok)) begin
            n_stopped = 1'b1;
        end
        if (last) begin
            n_third_pad = 1'b0;
            n_stopped   = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_third_pad <= 1'b0;
            r_stopped   <= 1'b0;
        end else if (i_adv) begin
            r_pos       <= n_pos;
            r_third_pad <= n_third_pad;
            r_stopped   <= n_stopped;
        end
    end

    // held symbols of the open group
    always_ff @(posedge i_clk) begin
        if (i_adv && r_pos != 2'd3) begin
            r_held[r_pos] <= v;
        end
    end

endmodule

// File: hw/rtl/base64url_stream_decoder_unit.sv
// top level of the base64url stream decoder: input register, group logic, result buffer
`timescale 1ns / 1ps

// channel  | direction | handshake          | payload
// input    | in        | i_valid / o_stall  | i_data  (t_in_item: in_char, in_last)
// output   | out       | o_valid / i_stall  | o_data  (t_out_item: out_byte, has_byte,
//          |           |                    |          run_last, message_end)
//
// one character beat is taken per cycle while the input is not stalled; its zero to three
// result beats leave one per cycle from the result buffer while the output is not stalled,
// so while the buffer drains the results of a full group, the next character waits in the input register.
// an input beat passes through the input register and then the result buffer before its first result beat leaves.
// reset is synchronous, active low, and empties both registers; no clearing pass.
// a stalled output holds its beat; the input stalls only when the input register is full
// and the buffer cannot take its results.

module base64url_stream_decoder_unit
    import b64u_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic             r_in_valid;
    t_in_item         r_in;
    logic [1:0]       r_cnt;
    logic [1:0]       r_idx;
    logic             r_marker;
    logic             r_msg_end;
    logic [7:0]       r_bytes [MAX_RES];

    t_group_res       res;
    logic             in_acc;
    logic             out_acc;
    logic             buf_last;
    logic             buf_free;
    logic             adv;

    // handshake
    always_comb begin
        out_acc  = o_valid && !i_stall;
        buf_last = (r_idx == r_cnt - 2'd1);
        buf_free = (r_cnt == 2'd0) || (out_acc && buf_last);
        adv      = r_in_valid && buf_free;
        o_stall  = r_in_valid && !adv;
        in_acc   = i_valid && !o_stall;
        o_valid  = (r_cnt != 2'd0);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_data;
        end
    end

    b64u_group u_group (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (r_in),
        .o_res   (res)
    );

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (adv) begin
            r_cnt <= res.cnt;
            r_idx <= '0;
        end else if (out_acc) begin
            if (buf_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_marker  <= res.marker;
            r_msg_end <= res.msg_end;
            for (int k = 0; k < MAX_RES; k++) begin
                r_bytes[k] <= res.bytes[k];
            end
        end
    end

    // output beat
    always_comb begin
        o_data.out_byte    = r_bytes[r_idx];
        o_data.has_byte    = !r_marker;
        o_data.run_last    = buf_last;
        o_data.message_end = buf_last && r_msg_end;
    end

endmodule
